// ===== hw/rtl/wlm_pkg.sv =====
`timescale 1ns / 1ps

package wlm_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int POS_W        = 12;
  localparam int DIM_W        = 13;
  localparam int PIX_W        = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

  // register indexes of the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // one complete 3x3 neighborhood with the raster position of its newest pixel
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] win;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
  } win_entry_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== hw/rtl/wlm_front.sv =====
`timescale 1ns / 1ps

module wlm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_enable,
  input  logic                           cfg_index,
  input  logic [wlm_pkg::DIM_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wlm_pkg::PIX_W-1:0]      pixel_value,
  input  logic                           q_full,
  output logic                           q_push,
  output wlm_pkg::win_entry_t            q_data
);

  logic [wlm_pkg::DIM_W-1:0]  image_width;
  logic [wlm_pkg::DIM_W-1:0]  image_height;
  logic [wlm_pkg::DIM_W-1:0]  width_use;
  logic [wlm_pkg::DIM_W-1:0]  height_use;

  logic [wlm_pkg::POS_W-1:0]  col_cnt;
  logic [wlm_pkg::POS_W-1:0]  row_cnt;

  logic                       s1_valid;
  wlm_pkg::pix_t              s1_pix;
  logic [wlm_pkg::POS_W-1:0]  s1_row;
  logic [wlm_pkg::POS_W-1:0]  s1_col;
  wlm_pkg::pix_t              rd_upper;
  wlm_pkg::pix_t              rd_middle;

  logic [2:0][2:0][wlm_pkg::PIX_W-1:0] window;
  logic [2:0][2:0][wlm_pkg::PIX_W-1:0] window_next;

  wlm_pkg::pix_t upper_mem  [wlm_pkg::MAX_WIDTH];
  wlm_pkg::pix_t middle_mem [wlm_pkg::MAX_WIDTH];

  logic accept;
  logic s1_eval;
  logic s1_adv;

  assign width_use  = wlm_pkg::clamp_dim(image_width, wlm_pkg::DIM_W'(wlm_pkg::MAX_WIDTH));
  assign height_use = wlm_pkg::clamp_dim(image_height,
                                         wlm_pkg::DIM_W'(wlm_pkg::HEIGHT_LIMIT));

  assign s1_eval  = (s1_row >= wlm_pkg::POS_W'(2)) && (s1_col >= wlm_pkg::POS_W'(2));
  assign in_stall = s1_valid && s1_eval && q_full;
  assign accept   = in_valid && !in_stall;
  assign s1_adv   = s1_valid && !(s1_eval && q_full);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      window_next[k][0] = window[k][1];
      window_next[k][1] = window[k][2];
    end
    window_next[0][2] = rd_upper;
    window_next[1][2] = rd_middle;
    window_next[2][2] = s1_pix;
  end

  assign q_push      = s1_adv && s1_eval;
  assign q_data.win  = window_next;
  assign q_data.row  = s1_row;
  assign q_data.col  = s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= wlm_pkg::WIDTH_RESET;
      image_height <= wlm_pkg::HEIGHT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        wlm_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        wlm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if ({1'b0, col_cnt} + wlm_pkg::DIM_W'(1) >= width_use) begin
        col_cnt <= '0;
        if ({1'b0, row_cnt} + wlm_pkg::DIM_W'(1) >= height_use) row_cnt <= '0;
        else row_cnt <= row_cnt + wlm_pkg::POS_W'(1);
      end else begin
        col_cnt <= col_cnt + wlm_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel_value;
      s1_row <= row_cnt;
      s1_col <= col_cnt;
    end
  end

  // consecutive pixels always sit in different columns, so the read of the
  // new pixel never meets the write-back of the one ahead of it
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper  <= upper_mem[col_cnt[wlm_pkg::ADDR_W-1:0]];
      rd_middle <= middle_mem[col_cnt[wlm_pkg::ADDR_W-1:0]];
    end
    if (s1_adv) begin
      upper_mem[s1_col[wlm_pkg::ADDR_W-1:0]]  <= rd_middle;
      middle_mem[s1_col[wlm_pkg::ADDR_W-1:0]] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_adv) begin
      window <= window_next;
    end
  end

endmodule

// ===== hw/rtl/wlm_fifo.sv =====
`timescale 1ns / 1ps

module wlm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wlm_pkg::win_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output wlm_pkg::win_entry_t pop_data
);

  wlm_pkg::win_entry_t entries [wlm_pkg::QUEUE_DEPTH];

  logic [wlm_pkg::QPTR_W-1:0] wr_ptr;
  logic [wlm_pkg::QPTR_W-1:0] rd_ptr;
  logic [wlm_pkg::QPTR_W:0]   count;

  assign full      = (count == (wlm_pkg::QPTR_W + 1)'(wlm_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + wlm_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + wlm_pkg::QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (wlm_pkg::QPTR_W + 1)'(1);
        2'b01:   count <= count - (wlm_pkg::QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== hw/rtl/wlm_back.sv =====
`timescale 1ns / 1ps

module wlm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  wlm_pkg::win_entry_t           q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wlm_pkg::POS_W-1:0]     winner_row,
  output logic [wlm_pkg::POS_W-1:0]     winner_col,
  output logic [wlm_pkg::PIX_W-1:0]     winner_value
);

  // stage 1: best of each window row, first column wins a tie
  logic                      b1_valid;
  wlm_pkg::pix_t             b1_val  [3];
  logic [1:0]                b1_lidx [3];
  logic [wlm_pkg::POS_W-1:0] b1_row;
  logic [wlm_pkg::POS_W-1:0] b1_col;

  wlm_pkg::pix_t             row_val  [3];
  logic [1:0]                row_lidx [3];

  wlm_pkg::pix_t             best_val;
  logic [1:0]                best_k;
  logic [1:0]                best_l;

  logic b1_drop;
  logic out_free;
  logic b1_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_val[k]  = '0;
      row_lidx[k] = '0;
      for (int l = 0; l < 3; l++) begin
        if (q_data.win[k][l] > row_val[k]) begin
          row_val[k]  = q_data.win[k][l];
          row_lidx[k] = 2'(l);
        end
      end
    end
  end

  // stage 2: top row first, strict compare keeps the earliest maximum
  always_comb begin
    best_val = '0;
    best_k   = '0;
    best_l   = '0;
    for (int k = 0; k < 3; k++) begin
      if (b1_val[k] > best_val) begin
        best_val = b1_val[k];
        best_k   = 2'(k);
        best_l   = b1_lidx[k];
      end
    end
  end

  assign b1_drop  = (best_val == '0);
  assign out_free = !out_valid || !out_stall;
  assign b1_ready = !b1_valid || b1_drop || out_free;
  assign q_pop    = q_valid && b1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_ready) begin
      b1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < 3; k++) begin
        b1_val[k]  <= row_val[k];
        b1_lidx[k] <= row_lidx[k];
      end
      b1_row <= q_data.row;
      b1_col <= q_data.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= b1_valid && !b1_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      winner_value <= best_val;
      winner_row   <= b1_row - wlm_pkg::POS_W'(2) + wlm_pkg::POS_W'(best_k);
      winner_col   <= b1_col - wlm_pkg::POS_W'(2) + wlm_pkg::POS_W'(best_l);
    end
  end

endmodule

// ===== hw/rtl/window_local_max_marker_unit.sv =====
`timescale 1ns / 1ps
// Path from pixel beat to write-command beat:
// line store read, window shift, queue, row maxima, output register.
// Throughput: one pixel per cycle while the queue is not full; the line store
// port pair takes one read and one write per cycle. A four-entry queue parts
// the pixel and command sides. Reset: counters, window, queue and valids clear;
// width 640, height 480; line stores are not cleared and need no clearing pass.

module window_local_max_marker_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_enable,
  input  logic                          cfg_index,
  input  logic [wlm_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wlm_pkg::PIX_W-1:0]     pixel_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wlm_pkg::POS_W-1:0]     winner_row,
  output logic [wlm_pkg::POS_W-1:0]     winner_col,
  output logic [wlm_pkg::PIX_W-1:0]     winner_value
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  wlm_pkg::win_entry_t q_in;
  wlm_pkg::win_entry_t q_out;

  wlm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pixel_value      (pixel_value),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  wlm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  wlm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .winner_row   (winner_row),
    .winner_col   (winner_col),
    .winner_value (winner_value)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("window pushed into full queue");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("pixel side stalled while queue has room");

  a_nonzero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (winner_value != '0))
    else $error("write command with zero value");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

// ===== bench/tb_window_local_max_marker_unit.sv =====
`timescale 1ns / 1ps

module tb_window_local_max_marker_unit;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RESET_PIXELS  = 200;
  localparam int RANDOM_PIXELS = 950;

  typedef enum int {MIX_UNIFORM, MIX_SPARSE, MIX_LOW, MIX_ZERO, MIX_FULL} pix_mix_t;

  typedef struct {
    logic [wlm_pkg::POS_W-1:0] row;
    logic [wlm_pkg::POS_W-1:0] col;
    wlm_pkg::pix_t             value;
  } mark_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_enable = 1'b0;
  logic                      cfg_index = wlm_pkg::REG_IMAGE_WIDTH;
  logic [wlm_pkg::DIM_W-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  wlm_pkg::pix_t             pixel_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [wlm_pkg::POS_W-1:0] winner_row;
  logic [wlm_pkg::POS_W-1:0] winner_col;
  wlm_pkg::pix_t             winner_value;

  window_local_max_marker_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pixel_value      (pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .winner_row       (winner_row),
    .winner_col       (winner_col),
    .winner_value     (winner_value)
  );

  always #1 clk = ~clk;

  wlm_pkg::pix_t pixel_q[$];
  mark_t         mark_q[$];
  mark_t         due_mark;
  int            pixels_owed = 0;
  logic          pix_taken = 1'b0;
  logic          steady = 1'b0;
  int            fail_count = 0;
  int            idle_cycles = 0;

  // shadow of the block: line stores, 3x3 neighborhood, raster position, registers
  wlm_pkg::pix_t             upper_row_store[wlm_pkg::MAX_WIDTH];
  wlm_pkg::pix_t             middle_row_store[wlm_pkg::MAX_WIDTH];
  wlm_pkg::pix_t             nbhd[3][3];
  int                        col_pos;
  int                        row_pos;
  logic [wlm_pkg::DIM_W-1:0] width_cfg;
  logic [wlm_pkg::DIM_W-1:0] height_cfg;

  wlm_pkg::pix_t tie_frame[9] = '{8'd3, 8'd5, 8'd5, 8'd7, 8'd9, 8'd9, 8'd9, 8'd1, 8'd2};

  function automatic int eff_dim(logic [wlm_pkg::DIM_W-1:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    fail_count++;
  endtask

  task automatic mark_local_max(wlm_pkg::pix_t px);
    int            w;
    int            h;
    int            idx;
    wlm_pkg::pix_t best;
    mark_t         m;
    w = eff_dim(width_cfg, wlm_pkg::MAX_WIDTH);
    h = eff_dim(height_cfg, wlm_pkg::HEIGHT_LIMIT);
    idx = col_pos % wlm_pkg::MAX_WIDTH;
    for (int k = 0; k < 3; k++) begin
      nbhd[k][0] = nbhd[k][1];
      nbhd[k][1] = nbhd[k][2];
    end
    nbhd[0][2] = upper_row_store[idx];
    nbhd[1][2] = middle_row_store[idx];
    nbhd[2][2] = px;
    upper_row_store[idx] = middle_row_store[idx];
    middle_row_store[idx] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      best = '0;
      m.row = '0;
      m.col = '0;
      m.value = '0;
      // strict compare in raster order: the first of equal maxima wins
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          if (nbhd[k][l] > best) begin
            best = nbhd[k][l];
            m.row = wlm_pkg::POS_W'(row_pos - 2 + k);
            m.col = wlm_pkg::POS_W'(col_pos - 2 + l);
            m.value = best;
          end
        end
      end
      if (best != 0) mark_q.push_back(m);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) nbhd[k][l] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      width_cfg = wlm_pkg::WIDTH_RESET;
      height_cfg = wlm_pkg::HEIGHT_RESET;
      mark_q.delete();
      pix_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mark_q.size() == 0) begin
          report_mismatch("unexpected write command, value", 32'(winner_value), 32'(0));
        end else begin
          due_mark = mark_q.pop_front();
          if (winner_row !== due_mark.row)
            report_mismatch("winner_row", 32'(winner_row), 32'(due_mark.row));
          if (winner_col !== due_mark.col)
            report_mismatch("winner_col", 32'(winner_col), 32'(due_mark.col));
          if (winner_value !== due_mark.value)
            report_mismatch("winner_value", 32'(winner_value), 32'(due_mark.value));
        end
      end
      if (cfg_write_enable) begin
        if (cfg_index == wlm_pkg::REG_IMAGE_WIDTH) width_cfg = cfg_data;
        else height_cfg = cfg_data;
      end
      pix_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        mark_local_max(pixel_value);
        pixels_owed--;
      end
    end
  end

  // drive pixel beats and output stalls on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 25);
      if (!in_valid || pix_taken) begin
        if (pixel_q.size() > 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          in_valid <= 1'b1;
          pixel_value <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_window_local_max_marker_unit failed");
      $finish;
    end
  end

  function automatic wlm_pkg::pix_t pick_pixel(pix_mix_t mix);
    case (mix)
      MIX_SPARSE: return ($urandom_range(0, 9) < 8) ? wlm_pkg::pix_t'(0)
                                                    : wlm_pkg::pix_t'($urandom);
      MIX_LOW:    return wlm_pkg::pix_t'($urandom_range(0, 3));
      MIX_ZERO:   return '0;
      MIX_FULL:   return '1;
      default:    return wlm_pkg::pix_t'($urandom);
    endcase
  endfunction

  function automatic pix_mix_t pick_mix();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return MIX_UNIFORM;
    if (roll < 60) return MIX_SPARSE;
    if (roll < 85) return MIX_LOW;
    if (roll < 92) return MIX_FULL;
    return MIX_ZERO;
  endfunction

  // ceiling keeps a mid-frame write from widening the row
  function automatic logic [wlm_pkg::DIM_W-1:0] pick_width(int ceiling);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return wlm_pkg::DIM_W'($urandom_range(0, 2));
    if (roll < 75 || ceiling < 9)
      return wlm_pkg::DIM_W'($urandom_range(3, (ceiling < 8) ? ceiling : 8));
    if (roll < 95 || ceiling < 41)
      return wlm_pkg::DIM_W'($urandom_range(9, (ceiling < 40) ? ceiling : 40));
    return wlm_pkg::DIM_W'($urandom_range(41, (ceiling < 200) ? ceiling : 200));
  endfunction

  function automatic logic [wlm_pkg::DIM_W-1:0] pick_height(int w);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return wlm_pkg::DIM_W'($urandom_range(0, 2));
    if (roll < 85 || w > 8) return wlm_pkg::DIM_W'($urandom_range(3, 6));
    return wlm_pkg::DIM_W'($urandom_range(7, 20));
  endfunction

  function automatic int frame_remainder();
    int c;
    int r;
    int w;
    int h;
    int n;
    c = col_pos;
    r = row_pos;
    w = eff_dim(width_cfg, wlm_pkg::MAX_WIDTH);
    h = eff_dim(height_cfg, wlm_pkg::HEIGHT_LIMIT);
    n = 0;
    while (c != 0 || r != 0) begin
      n++;
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  task automatic write_reg(logic idx, logic [wlm_pkg::DIM_W-1:0] val);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic push_pixels(int n, pix_mix_t mix);
    for (int i = 0; i < n; i++) pixel_q.push_back(pick_pixel(mix));
    pixels_owed += n;
  endtask

  // wait for every beat to be taken and every write command to arrive
  task automatic settle();
    while (pixels_owed != 0 || mark_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int                        n;
    int                        random_sent;
    logic [wlm_pkg::DIM_W-1:0] w_raw;
    random_sent = 0;
    steady <= 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset width, no idling on either side
    push_pixels(RESET_PIXELS, MIX_SPARSE);
    settle();
    // narrow the frame mid-row so it closes after two short rows
    write_reg(wlm_pkg::REG_IMAGE_WIDTH, wlm_pkg::DIM_W'(2));
    write_reg(wlm_pkg::REG_IMAGE_HEIGHT, wlm_pkg::DIM_W'(0));
    push_pixels(frame_remainder(), MIX_UNIFORM);
    settle();

    // 3x3 frames: all zero, all full scale, tied peaks
    write_reg(wlm_pkg::REG_IMAGE_WIDTH, wlm_pkg::DIM_W'(2));
    push_pixels(9, MIX_ZERO);
    push_pixels(9, MIX_FULL);
    foreach (tie_frame[i]) pixel_q.push_back(tie_frame[i]);
    pixels_owed += 9;
    settle();
    steady <= 1'b0;

    while (random_sent < RANDOM_PIXELS) begin
      if (col_pos == 0 && row_pos == 0) begin
        w_raw = pick_width(200);
        write_reg(wlm_pkg::REG_IMAGE_WIDTH, w_raw);
        write_reg(wlm_pkg::REG_IMAGE_HEIGHT, pick_height(eff_dim(w_raw, wlm_pkg::MAX_WIDTH)));
      end else if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 1))
          write_reg(wlm_pkg::REG_IMAGE_WIDTH,
                    pick_width(eff_dim(width_cfg, wlm_pkg::MAX_WIDTH)));
        write_reg(wlm_pkg::REG_IMAGE_HEIGHT,
                  pick_height(eff_dim(width_cfg, wlm_pkg::MAX_WIDTH)));
      end
      n = $urandom_range(0, 1) ? frame_remainder() + $urandom_range(0, 4)
                               : $urandom_range(5, 80);
      push_pixels(n, pick_mix());
      random_sent += n;
      settle();
    end

    // close the frame
    write_reg(wlm_pkg::REG_IMAGE_HEIGHT, wlm_pkg::DIM_W'(0));
    push_pixels(frame_remainder(), MIX_LOW);
    settle();

    if (fail_count == 0)
      $display("tb_window_local_max_marker_unit passed");
    else
      $display("tb_window_local_max_marker_unit failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wlm_pkg.sv
hw/rtl/wlm_front.sv
hw/rtl/wlm_fifo.sv
hw/rtl/wlm_back.sv
hw/rtl/window_local_max_marker_unit.sv
bench/tb_window_local_max_marker_unit.sv
